// ===== hw/rtl/ntt_pkg.sv =====
// shared types and codes for the nat translation table
// no dependencies; imported by ntt_cell, nat_translation_table and the testbench
`default_nettype none

package ntt_pkg;

    // default number of cells in the chain
    localparam int NTT_SLOTS = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2
    } ntt_mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } ntt_status_t;

    // one binding as held in a cell
    typedef struct packed {
        logic [31:0] inner_addr;
        logic [15:0] inner_port;
        logic [31:0] outer_addr;
        logic [15:0] outer_port;
    } ntt_bind_t;

    // request broadcast to every cell
    typedef struct packed {
        logic        step;
        logic [1:0]  mode;
        logic [31:0] key_addr;
        logic [15:0] key_port;
        logic [31:0] xlat_addr;
        logic [15:0] xlat_port;
    } ntt_req_t;

    // priority link handed from cell to cell
    typedef struct packed {
        logic      seen;
        ntt_bind_t binding;
    } ntt_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ntt_cell.sv =====
// one cell of the translation table chain: a binding and its used flag
// depends on ntt_pkg
`default_nettype none

module ntt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ntt_pkg::ntt_req_t  req,
    input  wire logic               prev_used,
    input  wire logic               next_used,
    input  wire ntt_pkg::ntt_bind_t next_bind,
    input  wire ntt_pkg::ntt_link_t link_in,
    output ntt_pkg::ntt_link_t      link_out,
    output logic                    used,
    output ntt_pkg::ntt_bind_t      binding
);
    import ntt_pkg::*;

    logic      used_reg;
    logic      used_next;
    ntt_bind_t bind_reg;
    ntt_bind_t bind_next;
    logic      search;
    logic      match;
    logic      shift;
    logic      insert;
    logic      bind_load;

    assign search = (req.mode == MODE_DELETE) || (req.mode == MODE_FIND);

    assign match = used_reg && search &&
                   (((bind_reg.inner_addr == req.key_addr) &&
                     (bind_reg.inner_port == req.key_port)) ||
                    ((bind_reg.outer_addr == req.key_addr) &&
                     (bind_reg.outer_port == req.key_port)));

    // earliest match wins; later cells see the flag set
    assign link_out.seen    = link_in.seen | match;
    assign link_out.binding = (match && !link_in.seen) ? bind_reg : link_in.binding;

    // delete: this cell and all after the hit pull from the neighbor
    assign shift  = req.step && (req.mode == MODE_DELETE) && link_out.seen;
    // insert lands in the first free cell
    assign insert = req.step && (req.mode == MODE_INSERT) && !used_reg && prev_used;

    always_comb
    begin
        used_next = used_reg;
        bind_next = bind_reg;
        bind_load = 1'b0;
        if (shift)
        begin
            used_next = next_used;
            bind_next = next_bind;
            bind_load = 1'b1;
        end
        else if (insert)
        begin
            used_next            = 1'b1;
            bind_next.inner_addr = req.key_addr;
            bind_next.inner_port = req.key_port;
            bind_next.outer_addr = req.xlat_addr;
            bind_next.outer_port = req.xlat_port;
            bind_load            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bind_load)
        begin
            bind_reg <= bind_next;
        end
    end

    assign used    = used_reg;
    assign binding = bind_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nat_translation_table.sv =====
// top level of the nat translation table: request register, cell chain, result register
// depends on ntt_pkg and ntt_cell
`default_nettype none

// Ordered NAT binding table built as a chain of TABLE_SLOTS cells. Bindings sit packed
// in insertion order from cell 0 up. An insert (mode 0) lands in the first free cell and
// reports done, or full when the last cell is in use; the binding is then dropped. Find
// (mode 2) and delete (mode 1) match a key against both the internal and the translated
// pair of every cell at once; the earliest matching cell wins through a ripple link that
// runs from cell 0 to the last cell. Find reports the binding, delete reports it and all
// later cells move down one place in the same cycle. A miss, and mode 3, report not found
// with zero hit fields. Rate: one request per clock while the output does not stall; a
// request accepted into the request register is applied to the chain when it steps, and
// its result is registered in the result register at that edge. The ripple link through
// all cells sets the clock period. The next request is taken while a result still waits
// on a stalled output. No clearing pass after reset: only the used flags are reset.
module nat_translation_table #(
    parameter int TABLE_SLOTS = ntt_pkg::NTT_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] key_addr,
    input  wire logic [15:0] key_port,
    input  wire logic [31:0] xlat_addr,
    input  wire logic [15:0] xlat_port,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      hit_inner_addr,
    output logic [15:0]      hit_inner_port,
    output logic [31:0]      hit_outer_addr,
    output logic [15:0]      hit_outer_port
);
    import ntt_pkg::*;

    // request register
    logic        req_valid_reg;
    logic        req_valid_next;
    logic [1:0]  req_mode_reg;
    logic [31:0] req_key_addr_reg;
    logic [15:0] req_key_port_reg;
    logic [31:0] req_xlat_addr_reg;
    logic [15:0] req_xlat_port_reg;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    ntt_status_t status_reg;
    ntt_status_t status_next;
    ntt_bind_t   hit_reg;
    ntt_bind_t   hit_next;

    logic      step;
    logic      in_accept;
    ntt_req_t  req;

    // chain wiring
    logic [TABLE_SLOTS-1:0] used_vec;
    ntt_bind_t              bind_w [TABLE_SLOTS];
    ntt_link_t              link   [TABLE_SLOTS+1];

    // apply the pending request unless the result slot is blocked
    assign step      = req_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = req_valid_reg && !step;
    assign in_accept = in_valid && !in_stall;

    assign req.step      = step;
    assign req.mode      = req_mode_reg;
    assign req.key_addr  = req_key_addr_reg;
    assign req.key_port  = req_key_port_reg;
    assign req.xlat_addr = req_xlat_addr_reg;
    assign req.xlat_port = req_xlat_port_reg;

    // head of the priority link: nothing seen, zero binding
    assign link[0].seen    = 1'b0;
    assign link[0].binding = '0;

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        logic      prev_used;
        logic      next_used;
        ntt_bind_t next_bind;

        if (i == 0)
        begin : g_first
            assign prev_used = 1'b1;
        end
        else
        begin : g_mid
            assign prev_used = used_vec[i-1];
        end

        if (i == TABLE_SLOTS - 1)
        begin : g_last
            // the last cell empties on a shift
            assign next_used = 1'b0;
            assign next_bind = '0;
        end
        else
        begin : g_inner
            assign next_used = used_vec[i+1];
            assign next_bind = bind_w[i+1];
        end

        ntt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (req),
            .prev_used (prev_used),
            .next_used (next_used),
            .next_bind (next_bind),
            .link_in   (link[i]),
            .link_out  (link[i+1]),
            .used      (used_vec[i]),
            .binding   (bind_w[i])
        );
    end

    // result of the request being applied
    always_comb
    begin
        status_next = STATUS_MISS;
        hit_next    = '0;
        case (req_mode_reg)
            MODE_INSERT:
            begin
                status_next = used_vec[TABLE_SLOTS-1] ? STATUS_FULL : STATUS_DONE;
            end
            MODE_DELETE,
            MODE_FIND:
            begin
                // link tail carries zero binding on a miss
                status_next = link[TABLE_SLOTS].seen ? STATUS_DONE : STATUS_MISS;
                hit_next    = link[TABLE_SLOTS].binding;
            end
            default:
            begin
                status_next = STATUS_MISS;
            end
        endcase
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (step)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_mode_reg      <= mode;
            req_key_addr_reg  <= key_addr;
            req_key_port_reg  <= key_port;
            req_xlat_addr_reg <= xlat_addr;
            req_xlat_port_reg <= xlat_port;
        end
        if (step)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign hit_inner_addr = hit_reg.inner_addr;
    assign hit_inner_port = hit_reg.inner_port;
    assign hit_outer_addr = hit_reg.outer_addr;
    assign hit_outer_port = hit_reg.outer_port;

    // used flags stay packed from cell 0 up
    logic [TABLE_SLOTS-1:0] used_gap;
    assign used_gap = used_vec & (used_vec + TABLE_SLOTS'(1));

    a_used_packed: assert property (@(posedge clk) disable iff (!rst_n)
        used_gap == '0)
        else $error("used flags not packed");

    // insert into a full table reports full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step && req_mode_reg == MODE_INSERT && used_vec[TABLE_SLOTS-1])
        |=> (out_valid && status == STATUS_FULL))
        else $error("full insert not reported");

    // a delete hit frees exactly one cell
    a_delete_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (step && req_mode_reg == MODE_DELETE && link[TABLE_SLOTS].seen)
        |=> ($countones(used_vec) + 1 == $countones($past(used_vec))))
        else $error("delete did not free one cell");

    // a stalled result is not overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !step)
        else $error("result overwritten under stall");

endmodule

`default_nettype wire

// ===== verif/nat_translation_table_test.sv =====
// self-checking testbench for nat_translation_table: directed and random insert, delete
// and find requests checked against an in-bench binding tracker; depends on ntt_pkg
`timescale 1ns / 1ps

module nat_translation_table_test;

    import ntt_pkg::*;

    localparam int TABLE_SIZE = NTT_SLOTS;
    // the one mode value that the block has to ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // cycles without any accepted request or result before the run is abandoned
    localparam int STALL_LIMIT = 400;
    // long output hold-offs that back the table up into its input
    localparam int HOLD_START_A = 300;
    localparam int HOLD_LEN_A = 80;
    localparam int HOLD_START_B = 1400;
    localparam int HOLD_LEN_B = 50;
    // window in which neither side idles
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST = 1000;
    localparam int RANDOM_BLOCKS = 23;
    localparam int BLOCK_LEN = 50;

    // expected reply for one request
    typedef struct {
        ntt_status_t status;
        ntt_bind_t   binding;
    } table_reply_t;

    // tracks the bindings in insertion order and the replies still owed by the block
    class nat_binding_tracker;
        ntt_bind_t    bindings[$];
        table_reply_t expected_replies[$];
        int           failures;

        function void note_request(logic [1:0] op, logic [31:0] ka, logic [15:0] kp,
                                   logic [31:0] xa, logic [15:0] xp);
            table_reply_t reply;
            int           hit;
            reply.status = STATUS_MISS;
            reply.binding = '0;
            hit = -1;
            case (op)
                MODE_INSERT:
                begin
                    if (bindings.size() >= TABLE_SIZE)
                    begin
                        reply.status = STATUS_FULL;
                    end
                    else
                    begin
                        bindings.push_back('{ka, kp, xa, xp});
                        reply.status = STATUS_DONE;
                    end
                end
                MODE_DELETE, MODE_FIND:
                begin
                    // earliest binding whose inner or outer pair equals the key
                    for (int i = 0; i < bindings.size(); i++)
                    begin
                        if (hit < 0 &&
                            ((bindings[i].inner_addr == ka && bindings[i].inner_port == kp) ||
                             (bindings[i].outer_addr == ka && bindings[i].outer_port == kp)))
                        begin
                            hit = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        reply.status = STATUS_DONE;
                        reply.binding = bindings[hit];
                        if (op == MODE_DELETE)
                        begin
                            bindings.delete(hit);
                        end
                    end
                end
                default:
                begin
                    // unused mode: not found, table untouched
                end
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] ia, logic [15:0] ip,
                                   logic [31:0] oa, logic [15:0] op);
            table_reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("result with no request outstanding: status %0h", st);
                failures++;
                return;
            end
            want = expected_replies.pop_front();
            compare_field("status", {30'd0, want.status}, {30'd0, st});
            compare_field("hit_inner_addr", want.binding.inner_addr, ia);
            compare_field("hit_inner_port", {16'd0, want.binding.inner_port}, {16'd0, ip});
            compare_field("hit_outer_addr", want.binding.outer_addr, oa);
            compare_field("hit_outer_port", {16'd0, want.binding.outer_port}, {16'd0, op});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_INSERT;
    logic [31:0] key_addr = '0;
    logic [15:0] key_port = '0;
    logic [31:0] xlat_addr = '0;
    logic [15:0] xlat_port = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] hit_inner_addr;
    logic [15:0] hit_inner_port;
    logic [31:0] hit_outer_addr;
    logic [15:0] hit_outer_port;

    int cycle_count = 0;
    int idle_cycles = 0;

    nat_binding_tracker tracker = new();

    nat_translation_table #(
        .TABLE_SLOTS(TABLE_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .key_addr(key_addr),
        .key_port(key_port),
        .xlat_addr(xlat_addr),
        .xlat_port(xlat_port),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .hit_inner_addr(hit_inner_addr),
        .hit_inner_port(hit_inner_port),
        .hit_outer_addr(hit_outer_addr),
        .hit_outer_port(hit_outer_port)
    );

    always #5 clk = ~clk;

    // random idle decision shared by both sides, suppressed in the quiet window
    function automatic bit take_break();
        if (cycle_count >= QUIET_FIRST && cycle_count <= QUIET_LAST)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < 14;
    endfunction

    // results are taken at the rising edge; the watchdog counts edges with no traffic
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_result(status, hit_inner_addr, hit_inner_port,
                                 hit_outer_addr, hit_outer_port);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls plus two long hold-offs so the block backs up
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (cycle_count == HOLD_START_A)
            begin
                hold_left = HOLD_LEN_A;
            end
            else if (cycle_count == HOLD_START_B)
            begin
                hold_left = HOLD_LEN_B;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= take_break();
            end
        end
    end

    // offers one request from the falling edge on and returns at the falling edge after
    // it was taken; in_valid stays high across back-to-back requests
    task automatic send_request(logic [1:0] op, logic [31:0] ka, logic [15:0] kp,
                                logic [31:0] xa, logic [15:0] xp);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        key_addr <= ka;
        key_port <= kp;
        xlat_addr <= xa;
        xlat_port <= xp;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.note_request(op, ka, kp, xa, xp);
        @(negedge clk);
    endtask

    // key source: mostly pairs already in the table, some corner values, some noise
    task automatic pick_pair(output logic [31:0] a, output logic [15:0] p);
        int        roll;
        int        idx;
        ntt_bind_t b;
        roll = $urandom_range(99);
        if (tracker.bindings.size() > 0 && roll < 60)
        begin
            idx = $urandom_range(tracker.bindings.size() - 1);
            b = tracker.bindings[idx];
            if ($urandom_range(1))
            begin
                a = b.inner_addr;
                p = b.inner_port;
            end
            else
            begin
                a = b.outer_addr;
                p = b.outer_port;
            end
        end
        else if (roll < 78)
        begin
            case ($urandom_range(2))
                0: a = 32'h0000_0000;
                1: a = 32'hFFFF_FFFF;
                default: a = $urandom_range(3);
            endcase
            case ($urandom_range(2))
                0: p = 16'h0000;
                1: p = 16'hFFFF;
                default: p = 16'($urandom_range(3));
            endcase
        end
        else
        begin
            a = $urandom;
            p = 16'($urandom);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] ka;
        logic [15:0] kp;
        logic [31:0] xa;
        logic [15:0] xp;
        logic [1:0]  op;
        int          roll;
        int          bias;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lookups and the unused mode on an empty table
        send_request(MODE_FIND, 32'h0, 16'h0, 32'h0, 16'h0);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // extremes, mirrored bindings and a duplicate
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0);
        send_request(MODE_INSERT, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0);
        // key matches inner pair of the first binding and outer pair of the second
        send_request(MODE_FIND, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0);
        send_request(MODE_FIND, 32'h0, 16'h0, 32'h0, 16'h0);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0);
        // after the shift the second binding is now the earliest match
        send_request(MODE_FIND, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0);
        // fill up, then overflow
        while (tracker.bindings.size() < TABLE_SIZE)
        begin
            send_request(MODE_INSERT, $urandom, 16'($urandom), $urandom, 16'($urandom));
        end
        send_request(MODE_INSERT, 32'hA5A5_5A5A, 16'h5AA5, 32'h5A5A_A5A5, 16'hA55A);
        // delete the oldest on a full table, then miss on a non-empty one
        send_request(MODE_DELETE, tracker.bindings[0].inner_addr,
                     tracker.bindings[0].inner_port, 32'h0, 16'h0);
        send_request(MODE_DELETE, 32'h1357_9BDF, 16'h2468, 32'h0, 16'h0);

        // random blocks, each leaning toward filling, draining or mixing
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            bias = $urandom_range(2);
            for (int n = 0; n < BLOCK_LEN; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                begin
                    op = MODE_UNUSED;
                end
                else if (bias == 0)
                begin
                    op = (roll < 73) ? MODE_INSERT : (roll < 83) ? MODE_DELETE : MODE_FIND;
                end
                else if (bias == 1)
                begin
                    op = (roll < 18) ? MODE_INSERT : (roll < 78) ? MODE_DELETE : MODE_FIND;
                end
                else
                begin
                    op = (roll < 38) ? MODE_INSERT : (roll < 68) ? MODE_DELETE : MODE_FIND;
                end
                pick_pair(ka, kp);
                if ($urandom_range(1))
                begin
                    pick_pair(xa, xp);
                end
                else
                begin
                    xa = $urandom;
                    xp = 16'($urandom);
                end
                send_request(op, ka, kp, xa, xp);
            end
        end
        in_valid <= 1'b0;

        // drain, then keep the clock running to show any stray result from the pipeline
        while (tracker.expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (tracker.failures == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ntt_pkg.sv
hw/rtl/ntt_cell.sv
hw/rtl/nat_translation_table.sv
verif/nat_translation_table_test.sv
